@@ hw/rtl/pbt_pkg.sv @@
// shared types, codes and helpers for the permission bitmap table
package pbt_pkg;

    // field widths of one input item
    localparam int KIND_W     = 2;
    localparam int TERM_ID_W  = 10;
    localparam int BUS_ID_W   = 6;
    localparam int WORD_W     = 64;

    // default number of terminal words
    localparam int TERMINAL_COUNT_DEF = 1024;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;        // take the item fields and read its word
        logic clear_step;     // write zero to one word of the reset pass
        logic finish_single;  // write back or answer a single-word item
        logic sweep_step;     // one read-modify-write step of a bulk update
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic req_bulk;       // the offered item updates every terminal
        logic cnt_at_last;    // word counter on the last word
        logic cnt_at_end;     // word counter one past the last word
    } t_dp_stat;

    // set or clear one bit or the whole word
    function automatic logic [WORD_W-1:0] apply_update(
        input logic [WORD_W-1:0]   word,
        input logic                enable,
        input logic                all_bits,
        input logic [BUS_ID_W-1:0] bid
    );
        logic [WORD_W-1:0] mask;
        mask = all_bits ? {WORD_W{1'b1}} : (WORD_W'(1) << bid);
        return enable ? (word | mask) : (word & ~mask);
    endfunction

endpackage

@@ hw/rtl/pbt_ctrl.sv @@
// controller state machine of the permission bitmap table
module pbt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pbt_pkg::t_dp_stat i_stat,
    output pbt_pkg::t_dp_cmd  o_cmd
);
    import pbt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SWEEP
    } t_state;

    t_state r_state;
    logic   r_busy;

    // commands decoded from the current state
    always_comb begin
        o_cmd               = '0;
        o_cmd.capture       = (r_state == S_IDLE) && start;
        o_cmd.clear_step    = (r_state == S_CLEAR);
        o_cmd.finish_single = (r_state == S_LOOKUP);
        o_cmd.sweep_step    = (r_state == S_SWEEP);
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_stat.cnt_at_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= i_stat.req_bulk ? S_SWEEP : S_LOOKUP;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOKUP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                S_SWEEP: begin
                    if (i_stat.cnt_at_end) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = r_busy;

    // busy is low exactly in the idle state
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) == !r_busy)
        else $error("busy flag disagrees with state");

    // an accepted item makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !r_busy) |=> r_busy)
        else $error("item accepted but block not busy");

    // the lookup state of a single-word item is followed directly by idle
    a_lookup_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |=> (r_state == S_IDLE))
        else $error("lookup state held too long");

endmodule

@@ hw/rtl/pbt_datapath.sv @@
// table memory, word counter and result register of the permission bitmap table
module pbt_datapath #(
    parameter int TERMINAL_COUNT = pbt_pkg::TERMINAL_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pbt_pkg::KIND_W-1:0]   i_kind,
    input  logic                         i_all_terminals,
    input  logic                         i_all_businesses,
    input  logic [pbt_pkg::TERM_ID_W-1:0] i_terminal_id,
    input  logic [pbt_pkg::BUS_ID_W-1:0] i_business_id,
    input  pbt_pkg::t_dp_cmd             i_cmd,
    output pbt_pkg::t_dp_stat            o_stat,
    output logic                         o_strobe,
    output logic                         o_allowed
);
    import pbt_pkg::*;

    localparam int AW = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
    localparam int CW = $clog2(TERMINAL_COUNT + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(TERMINAL_COUNT - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TERMINAL_COUNT);

    logic [WORD_W-1:0] r_mem [TERMINAL_COUNT];
    logic [WORD_W-1:0] r_rd_data;

    // captured item
    logic [KIND_W-1:0]   r_kind;
    logic                r_all_bits;
    logic [BUS_ID_W-1:0] r_bus_id;
    logic [AW-1:0]       r_term_addr;
    logic                r_in_range;

    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_wr_addr;
    logic          r_res_valid;
    logic          r_res_allowed;

    logic [AW+TERM_ID_W-1:0] term_wide;
    logic [AW-1:0]           term_addr;
    logic                    in_range;
    logic                    is_update;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WORD_W-1:0]       wr_data;
    logic [WORD_W-1:0]       upd_word;

    // terminal index resized to the memory address
    assign term_wide = {{AW{1'b0}}, i_terminal_id};
    assign term_addr = term_wide[AW-1:0];
    assign in_range  = 32'(i_terminal_id) < TERMINAL_COUNT;
    assign is_update = (r_kind == KIND_ENABLE) || (r_kind == KIND_DISABLE);
    assign upd_word  = apply_update(r_rd_data, r_kind == KIND_ENABLE, r_all_bits, r_bus_id);

    // status
    always_comb begin
        o_stat             = '0;
        o_stat.req_bulk    = ((i_kind == KIND_ENABLE) || (i_kind == KIND_DISABLE))
                             && i_all_terminals;
        o_stat.cnt_at_last = (r_cnt == CNT_LAST);
        o_stat.cnt_at_end  = (r_cnt == CNT_END);
    end

    // memory port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = term_addr;
        wr_en   = 1'b0;
        wr_addr = r_term_addr;
        wr_data = upd_word;
        if (i_cmd.capture) begin
            rd_en = 1'b1;
        end
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[AW-1:0];
            wr_data = '0;
        end
        if (i_cmd.finish_single) begin
            wr_en = is_update && r_in_range;
        end
        if (i_cmd.sweep_step) begin
            rd_en   = !o_stat.cnt_at_end;
            rd_addr = r_cnt[AW-1:0];
            wr_en   = (r_cnt != '0);
            wr_addr = r_wr_addr;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // item capture and sweep write address
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind      <= i_kind;
            r_all_bits  <= i_all_businesses;
            r_bus_id    <= i_business_id;
            r_term_addr <= term_addr;
            r_in_range  <= in_range;
        end
        if (i_cmd.sweep_step) begin
            r_wr_addr <= r_cnt[AW-1:0];
        end
    end

    // word counter for the reset pass and bulk updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clear_step) begin
            r_cnt <= o_stat.cnt_at_last ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.sweep_step) begin
            r_cnt <= o_stat.cnt_at_end ? '0 : r_cnt + 1'b1;
        end
    end

    // result strobe and answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid   <= 1'b0;
            r_res_allowed <= 1'b0;
        end else begin
            r_res_valid   <= i_cmd.finish_single || (i_cmd.sweep_step && o_stat.cnt_at_end);
            r_res_allowed <= i_cmd.finish_single && (r_kind == KIND_QUERY) && r_in_range
                             && r_rd_data[r_bus_id];
        end
    end

    assign o_strobe  = r_res_valid;
    assign o_allowed = r_res_allowed;

    // a result follows only the end of an item
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(i_cmd.finish_single || (i_cmd.sweep_step && o_stat.cnt_at_end)))
        else $error("result without a finished item");

    // update items always answer zero
    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && $past(r_kind != KIND_QUERY)) |-> !r_res_allowed)
        else $error("update item answered allowed");

    // the counter never runs past the end of the table
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_END)
        else $error("word counter out of range");

endmodule

@@ hw/rtl/permission_bitmap_table.sv @@
// top level of the permission bitmap table
//
//  channel   handshake                   payload
//  item in   start high while busy low   i_kind, i_all_terminals, i_all_businesses,
//                                        i_terminal_id, i_business_id
//  result    o_strobe high for one cycle o_allowed
//
// A query or single-terminal update keeps busy high through its lookup state
// once it is taken (word read, then answer and write-back), so the next item
// waits until busy falls. An all-terminal update walks the table with one
// read-modify-write per cycle and holds busy until every word is written back.
// After reset a clearing pass zeroes the table, busy high until every word is written.
// Each item gives exactly one result in the same cycle as busy falls; the
// receiver cannot stall it.
module permission_bitmap_table #(
    parameter int TERMINAL_COUNT = pbt_pkg::TERMINAL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pbt_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_all_terminals,
    input  logic                          i_all_businesses,
    input  logic [pbt_pkg::TERM_ID_W-1:0] i_terminal_id,
    input  logic [pbt_pkg::BUS_ID_W-1:0]  i_business_id,
    output logic                          o_strobe,
    output logic                          o_allowed
);
    import pbt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    pbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // table and result path
    pbt_datapath #(
        .TERMINAL_COUNT (TERMINAL_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_kind),
        .i_all_terminals  (i_all_terminals),
        .i_all_businesses (i_all_businesses),
        .i_terminal_id    (i_terminal_id),
        .i_business_id    (i_business_id),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_strobe         (o_strobe),
        .o_allowed        (o_allowed)
    );

endmodule
